@@ hdl/scba_pkg.sv @@
// Shared types, register codes and reset constants of the size-class arena allocator.
package scba_pkg;

  localparam int SIZE_W          = 24;
  localparam int CAP_W           = 24;
  localparam int OUT_OFF_W       = 24;
  localparam int OUT_CNT_W       = 32;
  localparam int CFG_DATA_W      = 24;
  localparam int CFG_IDX_W       = 3;
  localparam int LIMIT_W         = 16;
  localparam int MED_LIMIT_W     = 20;
  localparam int BATCH_W         = 16;
  localparam int NUM_ARENAS      = 3;
  localparam int ARENA_IDX_W     = 2;

  localparam int OFFSET_BITS_DEF = 24;
  localparam int COUNT_BITS_DEF  = 32;
  localparam int ALIGN_LOG2      = 3;
  localparam int ALIGN_BYTES     = 1 << ALIGN_LOG2;

  localparam logic [LIMIT_W-1:0]     TINY_LIMIT_RST   = 16'd16;
  localparam logic [LIMIT_W-1:0]     SMALL_LIMIT_RST  = 16'd128;
  localparam logic [MED_LIMIT_W-1:0] MEDIUM_LIMIT_RST = 20'd1024;
  localparam logic [CAP_W-1:0]       TINY_CAP_RST     = 24'(64 * 1024);
  localparam logic [CAP_W-1:0]       SMALL_CAP_RST    = 24'(1 * 1024 * 1024);
  localparam logic [CAP_W-1:0]       MEDIUM_CAP_RST   = 24'(4 * 1024 * 1024);
  localparam logic [BATCH_W-1:0]     BATCH_LIMIT_RST  = 16'd1000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TINY_LIMIT      = 3'd0,
    REG_SMALL_LIMIT     = 3'd1,
    REG_MEDIUM_LIMIT    = 3'd2,
    REG_TINY_CAPACITY   = 3'd3,
    REG_SMALL_CAPACITY  = 3'd4,
    REG_MEDIUM_CAPACITY = 3'd5,
    REG_BATCH_LIMIT     = 3'd6
  } reg_idx_t;

  typedef enum logic [1:0] {
    REGION_TINY   = 2'd0,
    REGION_SMALL  = 2'd1,
    REGION_MEDIUM = 2'd2,
    REGION_HEAP   = 2'd3
  } region_t;

  typedef struct packed {
    logic [LIMIT_W-1:0]     tiny_limit;
    logic [LIMIT_W-1:0]     small_limit;
    logic [MED_LIMIT_W-1:0] medium_limit;
    logic [CAP_W-1:0]       tiny_capacity;
    logic [CAP_W-1:0]       small_capacity;
    logic [CAP_W-1:0]       medium_capacity;
    logic [BATCH_W-1:0]     batch_limit;
  } cfg_regs_t;

endpackage

@@ hdl/size_class_bump_arena_allocator.sv @@
// Top level of the size-class bump-pointer arena allocator.
//
// Each input transfer carries one request size; each result transfer reports where it was
// placed (tiny, small or medium arena, or heap spill), the byte offset, the serving arena's
// peak and allocation count, and the batch-reset status. Sustained rate is one request per
// clock while the output is not stalled. The input transfer loads the input register; the
// result register loads when the core takes the request, after one pass through the three
// arena fit checks and the fallback chain; a stalled output holds the request in the input
// register. The arena offsets, peaks and counts update in that same pass, so a following
// request sees them in the next cycle. The input register takes a new request while a
// result waits on a stalled output. Reset clears all state at once; there is no clearing
// pass. Write configuration only while no request is in flight.
module size_class_bump_arena_allocator import scba_pkg::*; #(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [SIZE_W-1:0]     in_request_size,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            out_region,
  output logic [OUT_OFF_W-1:0]  out_place_offset,
  output logic                  out_batch_reset,
  output logic [OUT_OFF_W-1:0]  out_region_peak,
  output logic [OUT_CNT_W-1:0]  out_region_allocations,
  output logic [OUT_CNT_W-1:0]  out_resets_done
);

  cfg_regs_t          cfg;
  logic               req_vld_r, req_vld_nxt;
  logic [SIZE_W-1:0]  req_size_r;
  logic               req_take;
  logic               in_xfer;

  scba_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Input register: accept whenever it is empty or its request moves on this cycle.
  assign in_ready = !req_vld_r || req_take;
  assign in_xfer  = in_valid && in_ready;

  always_comb begin
    req_vld_nxt = req_vld_r;
    if (in_xfer) req_vld_nxt = 1'b1;
    else if (req_take) req_vld_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r <= 1'b0;
    end else begin
      req_vld_r <= req_vld_nxt;
    end
  end

  // Hold the size until the core takes it.
  always_ff @(posedge clk) begin
    if (in_xfer) req_size_r <= in_request_size;
  end

  scba_core #(.OFFSET_BITS(OFFSET_BITS), .COUNT_BITS(COUNT_BITS)) u_core (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg                    (cfg),
    .req_vld                (req_vld_r),
    .req_size               (req_size_r),
    .req_take               (req_take),
    .out_ready              (out_ready),
    .out_valid              (out_valid),
    .out_region             (out_region),
    .out_place_offset       (out_place_offset),
    .out_batch_reset        (out_batch_reset),
    .out_region_peak        (out_region_peak),
    .out_region_allocations (out_region_allocations),
    .out_resets_done        (out_resets_done)
  );

endmodule

@@ hdl/scba_cfg.sv @@
// Configuration register file of the size-class arena allocator.
module scba_cfg import scba_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_regs_t             cfg
);

  cfg_regs_t cfg_r;
  cfg_regs_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_TINY_LIMIT:      cfg_nxt.tiny_limit      = cfg_wdata[LIMIT_W-1:0];
        REG_SMALL_LIMIT:     cfg_nxt.small_limit     = cfg_wdata[LIMIT_W-1:0];
        REG_MEDIUM_LIMIT:    cfg_nxt.medium_limit    = cfg_wdata[MED_LIMIT_W-1:0];
        REG_TINY_CAPACITY:   cfg_nxt.tiny_capacity   = cfg_wdata[CAP_W-1:0];
        REG_SMALL_CAPACITY:  cfg_nxt.small_capacity  = cfg_wdata[CAP_W-1:0];
        REG_MEDIUM_CAPACITY: cfg_nxt.medium_capacity = cfg_wdata[CAP_W-1:0];
        REG_BATCH_LIMIT:     cfg_nxt.batch_limit     = cfg_wdata[BATCH_W-1:0];
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tiny_limit      <= TINY_LIMIT_RST;
      cfg_r.small_limit     <= SMALL_LIMIT_RST;
      cfg_r.medium_limit    <= MEDIUM_LIMIT_RST;
      cfg_r.tiny_capacity   <= TINY_CAP_RST;
      cfg_r.small_capacity  <= SMALL_CAP_RST;
      cfg_r.medium_capacity <= MEDIUM_CAP_RST;
      cfg_r.batch_limit     <= BATCH_LIMIT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ hdl/scba_arena.sv @@
// Fit check of one bump-pointer arena: start and end, aligned when ALIGNED is set, and capacity compare.
module scba_arena import scba_pkg::*; #(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF,
  parameter bit ALIGNED     = 1'b1
) (
  input  logic [OFFSET_BITS-1:0] offset,
  input  logic [CAP_W-1:0]       capacity,
  input  logic [SIZE_W-1:0]      size,
  output logic                   fit,
  output logic [OFFSET_BITS-1:0] start,
  output logic [OFFSET_BITS-1:0] stop
);

  // Two guard bits keep rounded offset plus rounded size from wrapping.
  localparam int SUM_W = ((OFFSET_BITS > SIZE_W) ? OFFSET_BITS : SIZE_W) + 2;
  localparam logic [SUM_W-1:0] ALIGN_MASK = SUM_W'(ALIGN_BYTES - 1);
  localparam logic [SUM_W-1:0] OFF_MAX    = SUM_W'((64'd1 << OFFSET_BITS) - 64'd1);

  logic [SUM_W-1:0] off_w;
  logic [SUM_W-1:0] size_w;
  logic [SUM_W-1:0] start_w;
  logic [SUM_W-1:0] len_w;
  logic [SUM_W-1:0] stop_w;
  logic [SUM_W-1:0] cap_w;
  logic [SUM_W-1:0] cap_eff;

  always_comb begin
    off_w   = SUM_W'(offset);
    size_w  = SUM_W'(size);
    start_w = ALIGNED ? ((off_w + ALIGN_MASK) & ~ALIGN_MASK) : off_w;
    len_w   = ALIGNED ? ((size_w + ALIGN_MASK) & ~ALIGN_MASK) : size_w;
    stop_w  = start_w + len_w;
    cap_w   = SUM_W'(capacity);
    cap_eff = (cap_w > OFF_MAX) ? OFF_MAX : cap_w;
    fit     = (stop_w <= cap_eff);
    // On a fit both values are at most the saturated capacity.
    start   = start_w[OFFSET_BITS-1:0];
    stop    = stop_w[OFFSET_BITS-1:0];
  end

endmodule

@@ hdl/scba_core.sv @@
// Placement chain, arena state and result register of the size-class arena allocator.
module scba_core import scba_pkg::*; #(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cfg_regs_t            cfg,
  input  logic                 req_vld,
  input  logic [SIZE_W-1:0]    req_size,
  output logic                 req_take,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [1:0]           out_region,
  output logic [OUT_OFF_W-1:0] out_place_offset,
  output logic                 out_batch_reset,
  output logic [OUT_OFF_W-1:0] out_region_peak,
  output logic [OUT_CNT_W-1:0] out_region_allocations,
  output logic [OUT_CNT_W-1:0] out_resets_done
);

  logic [OFFSET_BITS-1:0] off_r   [NUM_ARENAS];
  logic [OFFSET_BITS-1:0] off_nxt [NUM_ARENAS];
  logic [OFFSET_BITS-1:0] peak_r   [NUM_ARENAS];
  logic [OFFSET_BITS-1:0] peak_nxt [NUM_ARENAS];
  logic [COUNT_BITS-1:0]  cnt_r   [NUM_ARENAS];
  logic [COUNT_BITS-1:0]  cnt_nxt [NUM_ARENAS];
  logic [BATCH_W-1:0]     batch_r, batch_nxt, batch_inc;
  logic [COUNT_BITS-1:0]  resets_r, resets_nxt;

  logic                   fit   [NUM_ARENAS];
  logic [OFFSET_BITS-1:0] start [NUM_ARENAS];
  logic [OFFSET_BITS-1:0] stop  [NUM_ARENAS];

  region_t                region;
  logic [ARENA_IDX_W-1:0] idx;
  logic                   is_tiny, is_small, is_medium;
  logic                   served, clear;

  logic                   out_valid_r, out_valid_nxt;
  logic [1:0]             region_r;
  logic [OUT_OFF_W-1:0]   place_r, peak_out_r;
  logic                   batch_reset_r;
  logic [OUT_CNT_W-1:0]   allocs_r, resets_out_r;

  scba_arena #(.OFFSET_BITS(OFFSET_BITS), .ALIGNED(1'b0)) u_tiny (
    .offset(off_r[REGION_TINY]), .capacity(cfg.tiny_capacity), .size(req_size),
    .fit(fit[REGION_TINY]), .start(start[REGION_TINY]), .stop(stop[REGION_TINY])
  );

  scba_arena #(.OFFSET_BITS(OFFSET_BITS), .ALIGNED(1'b1)) u_small (
    .offset(off_r[REGION_SMALL]), .capacity(cfg.small_capacity), .size(req_size),
    .fit(fit[REGION_SMALL]), .start(start[REGION_SMALL]), .stop(stop[REGION_SMALL])
  );

  scba_arena #(.OFFSET_BITS(OFFSET_BITS), .ALIGNED(1'b1)) u_medium (
    .offset(off_r[REGION_MEDIUM]), .capacity(cfg.medium_capacity), .size(req_size),
    .fit(fit[REGION_MEDIUM]), .start(start[REGION_MEDIUM]),
    .stop(stop[REGION_MEDIUM])
  );

  assign req_take = req_vld && (!out_valid_r || out_ready);

  // Class test in register order, then the fallback chain of each class.
  always_comb begin
    is_tiny   = (req_size <= SIZE_W'(cfg.tiny_limit));
    is_small  = (req_size <= SIZE_W'(cfg.small_limit));
    is_medium = (req_size <= SIZE_W'(cfg.medium_limit));
    region    = REGION_HEAP;
    if (is_tiny) begin
      if (fit[REGION_TINY]) region = REGION_TINY;
      else if (fit[REGION_SMALL]) region = REGION_SMALL;
    end else if (is_small) begin
      if (fit[REGION_SMALL]) region = REGION_SMALL;
      else if (fit[REGION_MEDIUM]) region = REGION_MEDIUM;
    end else if (is_medium) begin
      if (fit[REGION_MEDIUM]) region = REGION_MEDIUM;
    end
    idx = (region == REGION_HEAP) ? ARENA_IDX_W'(REGION_TINY) : region;
  end

  always_comb begin
    for (int i = 0; i < NUM_ARENAS; i++) begin
      off_nxt[i]  = off_r[i];
      peak_nxt[i] = peak_r[i];
      cnt_nxt[i]  = cnt_r[i];
    end
    batch_nxt  = batch_r;
    resets_nxt = resets_r;
    if (region != REGION_HEAP) begin
      off_nxt[idx] = stop[idx];
      cnt_nxt[idx] = cnt_r[idx] + COUNT_BITS'(1);
      if (stop[idx] > peak_r[idx]) peak_nxt[idx] = stop[idx];
    end
    // A zero-size spill places nothing and leaves the batch alone.
    served    = (region != REGION_HEAP) || (req_size != '0);
    batch_inc = batch_r + BATCH_W'(1);
    clear     = served && (batch_inc >= cfg.batch_limit);
    if (served) begin
      batch_nxt = clear ? '0 : batch_inc;
    end
    if (clear) begin
      for (int i = 0; i < NUM_ARENAS; i++) off_nxt[i] = '0;
      resets_nxt = resets_r + COUNT_BITS'(1);
    end
    out_valid_nxt = req_take ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_ARENAS; i++) begin
        off_r[i]  <= '0;
        peak_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
      batch_r     <= '0;
      resets_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (req_take) begin
        for (int i = 0; i < NUM_ARENAS; i++) begin
          off_r[i]  <= off_nxt[i];
          peak_r[i] <= peak_nxt[i];
          cnt_r[i]  <= cnt_nxt[i];
        end
        batch_r  <= batch_nxt;
        resets_r <= resets_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      region_r      <= region;
      batch_reset_r <= clear;
      resets_out_r  <= OUT_CNT_W'(resets_nxt);
      if (region == REGION_HEAP) begin
        place_r    <= '0;
        peak_out_r <= '0;
        allocs_r   <= '0;
      end else begin
        place_r    <= OUT_OFF_W'(start[idx]);
        peak_out_r <= OUT_OFF_W'(peak_nxt[idx]);
        allocs_r   <= OUT_CNT_W'(cnt_nxt[idx]);
      end
    end
  end

  assign out_valid              = out_valid_r;
  assign out_region             = region_r;
  assign out_place_offset       = place_r;
  assign out_batch_reset        = batch_reset_r;
  assign out_region_peak        = peak_out_r;
  assign out_region_allocations = allocs_r;
  assign out_resets_done        = resets_out_r;

endmodule

@@ hdl/scba_checker.sv @@
// Port-level checks of the size-class arena allocator and their bind.
module scba_checker import scba_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [1:0]            out_region,
  input logic [OUT_OFF_W-1:0]  out_place_offset,
  input logic                  out_batch_reset,
  input logic [OUT_OFF_W-1:0]  out_region_peak,
  input logic [OUT_CNT_W-1:0]  out_region_allocations,
  input logic [OUT_CNT_W-1:0]  out_resets_done
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_region)
      && $stable(out_place_offset) && $stable(out_batch_reset)
      && $stable(out_region_peak) && $stable(out_region_allocations)
      && $stable(out_resets_done))
    else $error("result changed while stalled");

  a_ready_only_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input blocked without an output stall");

  a_heap_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_region == REGION_HEAP |-> out_place_offset == '0
      && out_region_peak == '0 && out_region_allocations == '0)
    else $error("heap spill with nonzero arena fields");

  a_place_below_peak: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_region != REGION_HEAP |-> out_place_offset <= out_region_peak)
    else $error("placement offset above arena peak");

endmodule

bind size_class_bump_arena_allocator scba_checker u_scba_checker (.*);

@@ test/tb_top.sv @@
// Self-checking testbench for the size-class bump-pointer arena allocator.
module tb_top;
  import scba_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Index with no register behind it; writes to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

  localparam int    SETTLE_CYCLES    = 4;    // pipeline is two deep, give it a margin
  localparam int    TAIL_CYCLES      = 8;
  localparam int    RANDOM_PHASES    = 10;
  localparam int    ITEMS_PER_PHASE  = 200;
  localparam int    LONG_HOLD_AT     = 700;  // accepted requests before the long stall
  localparam int    LONG_HOLD_CYCLES = 300;
  localparam longint RUN_LIMIT_NS    = 5_000_000;

  typedef struct packed {
    region_t                region;
    logic [OUT_OFF_W-1:0]   place_offset;
    logic                   batch_reset;
    logic [OUT_OFF_W-1:0]   region_peak;
    logic [OUT_CNT_W-1:0]   region_allocations;
    logic [OUT_CNT_W-1:0]   resets_done;
  } alloc_result_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t              kind;
    logic [CFG_IDX_W-1:0]   reg_sel;
    logic [CFG_DATA_W-1:0]  value;    // register data, or the request size
    logic                   typed;    // 1: check against the result typed into the row
    alloc_result_t          want;
  } plan_row_t;

  localparam alloc_result_t UNCHECKED = '{REGION_HEAP, '0, 1'b0, '0, '0, '0};
  localparam alloc_result_t HEAP_NONE = '{REGION_HEAP, '0, 1'b0, '0, '0, '0};

  // Directed walk, starting from the reset register values. Rows with typed results
  // follow directly from the class limits and the bump arithmetic; the rest go through
  // the predictor.
  localparam plan_row_t DIRECTED_PLAN [38] = '{
    // class boundaries: zero, tiny max, small min/max, medium min/max
    '{ROW_REQ, REG_UNMAPPED, 24'd0,       1'b1, '{REGION_TINY,   24'd0,   1'b0, 24'd0,    32'd1, 32'd0}},
    '{ROW_REQ, REG_UNMAPPED, 24'd16,      1'b1, '{REGION_TINY,   24'd0,   1'b0, 24'd16,   32'd2, 32'd0}},
    '{ROW_REQ, REG_UNMAPPED, 24'd17,      1'b1, '{REGION_SMALL,  24'd0,   1'b0, 24'd24,   32'd1, 32'd0}},
    '{ROW_REQ, REG_UNMAPPED, 24'd128,     1'b1, '{REGION_SMALL,  24'd24,  1'b0, 24'd152,  32'd2, 32'd0}},
    '{ROW_REQ, REG_UNMAPPED, 24'd129,     1'b1, '{REGION_MEDIUM, 24'd0,   1'b0, 24'd136,  32'd1, 32'd0}},
    '{ROW_REQ, REG_UNMAPPED, 24'd1024,    1'b1, '{REGION_MEDIUM, 24'd136, 1'b0, 24'd1160, 32'd2, 32'd0}},
    // large requests spill, including the widest size
    '{ROW_REQ, REG_UNMAPPED, 24'd1025,    1'b1, HEAP_NONE},
    '{ROW_REQ, REG_UNMAPPED, 24'hFFFFFF,  1'b1, HEAP_NONE},
    // tiny arena packs bytes without alignment, small rounds to 8
    '{ROW_REQ, REG_UNMAPPED, 24'd3,       1'b1, '{REGION_TINY,   24'd16,  1'b0, 24'd19,   32'd3, 32'd0}},
    '{ROW_REQ, REG_UNMAPPED, 24'd5,       1'b1, '{REGION_TINY,   24'd19,  1'b0, 24'd24,   32'd4, 32'd0}},
    '{ROW_REQ, REG_UNMAPPED, 24'd20,      1'b1, '{REGION_SMALL,  24'd152, 1'b0, 24'd176,  32'd3, 32'd0}},
    // tiny capacity lowered below its offset: tiny falls back to small
    '{ROW_CFG, REG_TINY_CAPACITY,   24'd10,      1'b0, UNCHECKED},
    '{ROW_REQ, REG_UNMAPPED,        24'd1,       1'b0, UNCHECKED},
    // small arena closed: small falls back to medium, tiny never reaches medium
    '{ROW_CFG, REG_SMALL_CAPACITY,  24'd0,       1'b0, UNCHECKED},
    '{ROW_REQ, REG_UNMAPPED,        24'd100,     1'b0, UNCHECKED},
    '{ROW_REQ, REG_UNMAPPED,        24'd1,       1'b1, HEAP_NONE},
    // zero-byte spill: not served, batch counter holds
    '{ROW_REQ, REG_UNMAPPED,        24'd0,       1'b1, HEAP_NONE},
    '{ROW_CFG, REG_TINY_CAPACITY,   24'hFFFFFF,  1'b0, UNCHECKED},
    '{ROW_CFG, REG_SMALL_CAPACITY,  24'hFFFFFF,  1'b0, UNCHECKED},
    // limits out of order: tiny test wins
    '{ROW_CFG, REG_TINY_LIMIT,      24'd200,     1'b0, UNCHECKED},
    '{ROW_REQ, REG_UNMAPPED,        24'd150,     1'b0, UNCHECKED},
    '{ROW_CFG, REG_MEDIUM_LIMIT,    24'd0,       1'b0, UNCHECKED},
    '{ROW_REQ, REG_UNMAPPED,        24'd300,     1'b0, UNCHECKED},
    // batch limit zero: every served request clears
    '{ROW_CFG, REG_BATCH_LIMIT,     24'd0,       1'b0, UNCHECKED},
    '{ROW_REQ, REG_UNMAPPED,        24'd8,       1'b0, UNCHECKED},
    '{ROW_REQ, REG_UNMAPPED,        24'hFFFFFF,  1'b0, UNCHECKED},
    '{ROW_CFG, REG_BATCH_LIMIT,     24'd1,       1'b0, UNCHECKED},
    '{ROW_CFG, REG_UNMAPPED,        24'hFFFFFF,  1'b0, UNCHECKED},
    '{ROW_REQ, REG_UNMAPPED,        24'd40,      1'b0, UNCHECKED},
    // limits at their extremes
    '{ROW_CFG, REG_TINY_LIMIT,      24'd0,       1'b0, UNCHECKED},
    '{ROW_CFG, REG_SMALL_LIMIT,     24'hFFFF,    1'b0, UNCHECKED},
    '{ROW_CFG, REG_MEDIUM_LIMIT,    24'hFFFFF,   1'b0, UNCHECKED},
    '{ROW_CFG, REG_MEDIUM_CAPACITY, 24'hFFFFFF,  1'b0, UNCHECKED},
    '{ROW_CFG, REG_BATCH_LIMIT,     24'hFFFF,    1'b0, UNCHECKED},
    '{ROW_REQ, REG_UNMAPPED,        24'd0,       1'b0, UNCHECKED},
    '{ROW_REQ, REG_UNMAPPED,        24'hFFFF,    1'b0, UNCHECKED},
    '{ROW_REQ, REG_UNMAPPED,        24'hFFFFF,   1'b0, UNCHECKED},
    '{ROW_REQ, REG_UNMAPPED,        24'h100000,  1'b0, UNCHECKED}
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [SIZE_W-1:0]     in_request_size = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [1:0]            out_region;
  logic [OUT_OFF_W-1:0]  out_place_offset;
  logic                  out_batch_reset;
  logic [OUT_OFF_W-1:0]  out_region_peak;
  logic [OUT_CNT_W-1:0]  out_region_allocations;
  logic [OUT_CNT_W-1:0]  out_resets_done;

  size_class_bump_arena_allocator DUT (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_we                 (cfg_we),
    .cfg_index              (cfg_index),
    .cfg_wdata              (cfg_wdata),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_request_size        (in_request_size),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_region             (out_region),
    .out_place_offset       (out_place_offset),
    .out_batch_reset        (out_batch_reset),
    .out_region_peak        (out_region_peak),
    .out_region_allocations (out_region_allocations),
    .out_resets_done        (out_resets_done)
  );

  // Shadow of the allocator: register copy plus the three bump arenas.
  cfg_regs_t            shadow;
  logic [OUT_OFF_W-1:0] arena_off    [NUM_ARENAS];
  logic [OUT_OFF_W-1:0] arena_peak   [NUM_ARENAS];
  logic [OUT_CNT_W-1:0] arena_allocs [NUM_ARENAS];
  logic [BATCH_W-1:0]   batch_fill;
  logic [OUT_CNT_W-1:0] batch_clears;

  alloc_result_t placements_due [$];

  int unsigned requests_accepted = 0;
  int unsigned placements_checked = 0;
  int unsigned mismatches = 0;
  int unsigned settings_used = 0;
  int unsigned clears_seen = 0;
  int unsigned region_seen [4] = '{0, 0, 0, 0};
  int unsigned burst_left = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic logic [63:0] align_up(input logic [63:0] v);
    return (v + 64'(ALIGN_BYTES - 1)) & ~64'(ALIGN_BYTES - 1);
  endfunction

  // Bump one arena if the request fits; tiny is byte-granular, the others 8-byte.
  function automatic bit fit_arena(input int which, input logic [SIZE_W-1:0] size,
                                   output logic [OUT_OFF_W-1:0] place);
    logic [63:0] start_at;
    logic [63:0] span;
    logic [63:0] end_at;
    logic [63:0] room;
    case (which)
      0:       room = 64'(shadow.tiny_capacity);
      1:       room = 64'(shadow.small_capacity);
      default: room = 64'(shadow.medium_capacity);
    endcase
    start_at = (which == 0) ? 64'(arena_off[which]) : align_up(64'(arena_off[which]));
    span     = (which == 0) ? 64'(size) : align_up(64'(size));
    end_at   = start_at + span;
    place    = '0;
    // an offset left above a lowered capacity keeps failing until the next clear
    if (end_at > room) return 1'b0;
    place = start_at[OUT_OFF_W-1:0];
    arena_off[which] = end_at[OUT_OFF_W-1:0];
    arena_allocs[which] = arena_allocs[which] + 1'b1;
    if (end_at[OUT_OFF_W-1:0] > arena_peak[which]) arena_peak[which] = end_at[OUT_OFF_W-1:0];
    return 1'b1;
  endfunction

  function automatic alloc_result_t place_request(input logic [SIZE_W-1:0] size);
    alloc_result_t        r;
    logic [OUT_OFF_W-1:0] spot;
    region_t              dest;
    logic                 cleared;
    dest    = REGION_HEAP;
    cleared = 1'b0;
    // class tests run in fixed order, whatever the limits look like
    if (size <= shadow.tiny_limit) begin
      if (fit_arena(0, size, spot)) dest = REGION_TINY;
      else if (fit_arena(1, size, spot)) dest = REGION_SMALL;
    end else if (size <= shadow.small_limit) begin
      if (fit_arena(1, size, spot)) dest = REGION_SMALL;
      else if (fit_arena(2, size, spot)) dest = REGION_MEDIUM;
    end else if (size <= shadow.medium_limit) begin
      if (fit_arena(2, size, spot)) dest = REGION_MEDIUM;
    end
    // a zero-byte spill hands out nothing and leaves the batch alone
    if (dest != REGION_HEAP || size != '0) begin
      batch_fill = batch_fill + 1'b1;
      if (batch_fill >= shadow.batch_limit) begin
        foreach (arena_off[i]) arena_off[i] = '0;
        batch_fill   = '0;
        batch_clears = batch_clears + 1'b1;
        cleared      = 1'b1;
      end
    end
    r.region             = dest;
    r.place_offset       = (dest == REGION_HEAP) ? '0 : spot;
    r.batch_reset        = cleared;
    r.region_peak        = (dest == REGION_HEAP) ? '0 : arena_peak[int'(dest)];
    r.region_allocations = (dest == REGION_HEAP) ? '0 : arena_allocs[int'(dest)];
    r.resets_done        = batch_clears;
    return r;
  endfunction

  function automatic void shadow_write(input logic [CFG_IDX_W-1:0] sel,
                                       input logic [CFG_DATA_W-1:0] value);
    case (sel)
      REG_TINY_LIMIT:      shadow.tiny_limit      = value[LIMIT_W-1:0];
      REG_SMALL_LIMIT:     shadow.small_limit     = value[LIMIT_W-1:0];
      REG_MEDIUM_LIMIT:    shadow.medium_limit    = value[MED_LIMIT_W-1:0];
      REG_TINY_CAPACITY:   shadow.tiny_capacity   = value[CAP_W-1:0];
      REG_SMALL_CAPACITY:  shadow.small_capacity  = value[CAP_W-1:0];
      REG_MEDIUM_CAPACITY: shadow.medium_capacity = value[CAP_W-1:0];
      REG_BATCH_LIMIT:     shadow.batch_limit     = value[BATCH_W-1:0];
      default: ;
    endcase
  endfunction

  // Mostly sizes inside the configured classes, plus boundaries, noise and tiny values.
  function automatic logic [SIZE_W-1:0] next_size();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 28) return SIZE_W'($urandom_range(0, shadow.tiny_limit));
    if (pick < 50) return SIZE_W'($urandom_range(0, shadow.small_limit));
    if (pick < 72) return SIZE_W'($urandom_range(0, shadow.medium_limit));
    if (pick < 82) begin
      case ($urandom_range(0, 5))
        0:       return SIZE_W'(shadow.tiny_limit);
        1:       return SIZE_W'(shadow.tiny_limit) + 1'b1;
        2:       return SIZE_W'(shadow.small_limit);
        3:       return SIZE_W'(shadow.small_limit) + 1'b1;
        4:       return SIZE_W'(shadow.medium_limit);
        default: return SIZE_W'(shadow.medium_limit) + 1'b1;
      endcase
    end
    if (pick < 92) return SIZE_W'($urandom_range(0, 24'hFFFFFF));
    return SIZE_W'($urandom_range(0, 8));
  endfunction

  function automatic logic [CAP_W-1:0] random_capacity();
    // small capacities fill up within a phase; an occasional wide one keeps high bits busy
    if ($urandom_range(0, 3) == 0) return CAP_W'($urandom_range(0, 24'hFFFFFF));
    return CAP_W'($urandom_range(0, 20000));
  endfunction

  function automatic void check_field(input string field, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t ns: %s mismatch: expected 0x%0h, got 0x%0h", $time, field, want, got);
    end
  endfunction

  // Offer one request and hold it until the transfer; the sender may idle between bursts.
  task automatic push_request(input logic [SIZE_W-1:0] size, input logic typed,
                              input alloc_result_t want);
    int unsigned   gap;
    alloc_result_t predicted;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 48);
    end
    burst_left--;
    in_valid        <= 1'b1;
    in_request_size <= size;
    do @(posedge clk); while (!in_ready);
    predicted = place_request(size);
    placements_due.push_back(typed ? want : predicted);
    requests_accepted++;
  endtask

  // Drop valid and wait until every placement is back and the pipeline is empty.
  task automatic wait_idle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (placements_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] sel, input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_wdata <= value;
    @(posedge clk);
    shadow_write(sel, value);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_phase(input int phase);
    cfg_regs_t pick;
    case (phase)
      0: pick = '{16'hFFFF, 16'hFFFF, 20'hFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF};
      1: pick = '{16'd0, 16'd0, 20'd0, 24'd0, 24'd0, 24'd0, 16'd1};
      default: begin
        pick.tiny_limit      = LIMIT_W'($urandom_range(0, 64));
        pick.small_limit     = LIMIT_W'($urandom_range(0, 600));
        pick.medium_limit    = MED_LIMIT_W'($urandom_range(0, 6000));
        pick.tiny_capacity   = random_capacity();
        pick.small_capacity  = random_capacity();
        pick.medium_capacity = random_capacity();
        pick.batch_limit     = (phase == 2) ? '0 : BATCH_W'($urandom_range(1, 300));
      end
    endcase
    write_reg(REG_TINY_LIMIT,      CFG_DATA_W'(pick.tiny_limit));
    write_reg(REG_SMALL_LIMIT,     CFG_DATA_W'(pick.small_limit));
    write_reg(REG_MEDIUM_LIMIT,    CFG_DATA_W'(pick.medium_limit));
    write_reg(REG_TINY_CAPACITY,   pick.tiny_capacity);
    write_reg(REG_SMALL_CAPACITY,  pick.small_capacity);
    write_reg(REG_MEDIUM_CAPACITY, pick.medium_capacity);
    write_reg(REG_BATCH_LIMIT,     CFG_DATA_W'(pick.batch_limit));
    write_reg(REG_UNMAPPED,        CFG_DATA_W'($urandom));
  endtask

  // Main sequence: reset, directed table, then random phases with fresh register settings.
  initial begin : stimulus
    shadow = '{TINY_LIMIT_RST, SMALL_LIMIT_RST, MEDIUM_LIMIT_RST, TINY_CAP_RST,
               SMALL_CAP_RST, MEDIUM_CAP_RST, BATCH_LIMIT_RST};
    foreach (arena_off[i]) begin
      arena_off[i]    = '0;
      arena_peak[i]   = '0;
      arena_allocs[i] = '0;
    end
    batch_fill   = '0;
    batch_clears = '0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < $size(DIRECTED_PLAN); i++) begin
      if (DIRECTED_PLAN[i].kind == ROW_CFG) begin
        wait_idle();
        write_reg(DIRECTED_PLAN[i].reg_sel, DIRECTED_PLAN[i].value);
      end else begin
        push_request(DIRECTED_PLAN[i].value, DIRECTED_PLAN[i].typed, DIRECTED_PLAN[i].want);
      end
    end
    settings_used = 1;

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_idle();
      program_phase(phase);
      settings_used++;
      repeat (ITEMS_PER_PHASE) push_request(next_size(), 1'b0, UNCHECKED);
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("checked %0d placements from %0d requests over %0d register settings",
             placements_checked, requests_accepted, settings_used);
    $display("tiny %0d, small %0d, medium %0d, heap %0d, batch clears %0d",
             region_seen[0], region_seen[1], region_seen[2], region_seen[3], clears_seen);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Result side stalls on a pattern that is redrawn at random now and again, and holds off once
  // for a long stretch so the input side backs up.
  initial begin : result_stall
    int unsigned cyc;
    int unsigned mode;
    bit          long_hold_done;
    cyc            = 0;
    mode           = 0;
    long_hold_done = 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (!long_hold_done && requests_accepted >= LONG_HOLD_AT) begin
        long_hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end else begin
        if (cyc % 50 == 0) mode = $urandom_range(0, 3);
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= ($urandom_range(0, 3) != 0);
          2:       out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= (cyc % 2 == 0);
        endcase
      end
    end
  end

  // Compare every result transfer with the oldest expected placement.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (placements_due.size() == 0) begin
        mismatches++;
        $display("%0t ns: unexpected result, region 0x%0h offset 0x%0h",
                 $time, out_region, out_place_offset);
      end else begin
        check_field("region",             32'(placements_due[0].region), 32'(out_region));
        check_field("place_offset",       32'(placements_due[0].place_offset),
                    32'(out_place_offset));
        check_field("batch_reset",        32'(placements_due[0].batch_reset),
                    32'(out_batch_reset));
        check_field("region_peak",        32'(placements_due[0].region_peak),
                    32'(out_region_peak));
        check_field("region_allocations", placements_due[0].region_allocations,
                    out_region_allocations);
        check_field("resets_done",        placements_due[0].resets_done, out_resets_done);
        region_seen[placements_due[0].region]++;
        if (placements_due[0].batch_reset) clears_seen++;
        void'(placements_due.pop_front());
        placements_checked++;
      end
    end
  end

  initial begin : run_limit
    #(RUN_LIMIT_NS);
    $display("run limit reached with %0d placements outstanding", placements_due.size());
    $display("simulation failed");
    $finish;
  end

endmodule
